@@ rtl/keyword_lexer_assert.svh @@
// assertion helpers shared by the lexer modules
// every user module has i_clk and i_rst_n in scope
`ifndef KEYWORD_LEXER_ASSERT_SVH
`define KEYWORD_LEXER_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define KL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition at one edge implies result at the next edge
`define KL_ASSERT_NEXT(lbl, cond, res, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (res)) \
        else $error(msg);
`else
`define KL_ASSERT(lbl, prop, msg)
`define KL_ASSERT_NEXT(lbl, cond, res, msg)
`endif

`endif

@@ rtl/kl_pkg.sv @@
package kl_pkg;

    localparam int unsigned OFFSET_BITS_DEF = 16;
    localparam int unsigned START_W         = 16;
    localparam int unsigned LEN_W           = 16;
    localparam int unsigned KW_IDX_W        = 4;
    localparam int unsigned NUM_KW          = 12;
    localparam int unsigned KW_MAX_LEN      = 6;
    localparam int unsigned KW_POS_W        = $clog2(KW_MAX_LEN);
    localparam int unsigned Q_DEPTH         = 4;
    localparam int unsigned Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W         = $clog2(Q_DEPTH + 1);

    localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
    localparam logic [NUM_KW-1:0] CAND_ALL = '1;

    // token kind codes as seen on the output
    typedef enum logic [1:0] {
        KIND_KEYWORD  = 2'd0,
        KIND_IDENT    = 2'd1,
        KIND_NUMBER   = 2'd2,
        KIND_OPERATOR = 2'd3
    } t_kind;

    // keyword spelling, zero padded, in index order
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "a", "t", 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n"},
        '{"s", "t", "r", "i", "n", "g"},
        '{"c", "h", "a", "r", 8'h00, 8'h00},
        '{"b", "o", "o", "l", 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00}
    };

    localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
        16'd3, 16'd5, 16'd2, 16'd4, 16'd5, 16'd3,
        16'd6, 16'd6, 16'd4, 16'd4, 16'd4, 16'd5
    };

    // one token as the front closes it, keyword not yet resolved
    typedef struct packed {
        logic                valid;
        t_kind               kind;
        logic [NUM_KW-1:0]   cand;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    len;
        logic [7:0]          op;
    } t_tok;

    // everything caused by one source byte
    typedef struct packed {
        t_tok first;
        t_tok second;
    } t_bundle;

    // finished result record
    typedef struct packed {
        t_kind                kind;
        logic [KW_IDX_W-1:0]  kw_idx;
        logic [START_W-1:0]   start;
        logic [LEN_W-1:0]     len;
        logic [7:0]           op;
    } t_rec;

    // drop every keyword that disagrees with byte b at position pos
    function automatic logic [NUM_KW-1:0] cand_step(
        input logic [NUM_KW-1:0] cand,
        input logic [LEN_W-1:0]  pos,
        input logic [7:0]        b
    );
        logic [NUM_KW-1:0] res;
        res = cand;
        for (int k = 0; k < NUM_KW; k++) begin
            if (pos >= KW_LEN[k]) begin
                res[k] = 1'b0;
            end else if (KW_TEXT[k][pos[KW_POS_W-1:0]] != b) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/keyword_lexer.sv @@
// Keyword lexer: takes source text one byte per request on the s_axis side
// (tlast marks the final byte of a text and flushes any open token) and gives
// token records on the m_axis side: keyword, identifier, number or operator,
// with start offset and length. A byte that closes a token and is an operator,
// or whose tlast flushes another open token, causes two records, sent in turn.
// The front scanner runs at one byte per cycle unless stalled; a four-entry
// queue of per-byte bundles sits between it and the output serializer, so the
// input stalls only when that queue is full. A record passes through a queue
// entry and then the serializer's record register. The offset counter is
// OFFSET_BITS wide and wraps; token_start carries its low 16 bits.
module keyword_lexer #(
    parameter int unsigned OFFSET_BITS = kl_pkg::OFFSET_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] source_byte
    input  logic         s_axis_tlast,   // end_of_source
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] keyword_index, [19:4] token_start, [35:20] token_length,
    // [43:36] operator_byte, [47:44] zero
    output logic [47:0]  m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] token_kind
    output logic         m_axis_tlast    // run_last
);
    import kl_pkg::*;

    logic     push, full, q_valid, q_pop;
    t_bundle  push_data, q_data;
    t_rec     rec;

    kl_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_eos    (s_axis_tlast),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (push_data)
    );

    kl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    kl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_rec     (rec),
        .o_last    (m_axis_tlast)
    );

    // output packing
    assign m_axis_tdata = {4'b0000, rec.op, rec.len, rec.start, rec.kw_idx};
    assign m_axis_tuser = rec.kind;

endmodule

@@ rtl/kl_front.sv @@
`include "keyword_lexer_assert.svh"

module kl_front #(
    parameter int unsigned OFFSET_BITS = kl_pkg::OFFSET_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_eos,
    input  logic             i_full,
    output logic             o_push,
    output kl_pkg::t_bundle  o_bundle
);
    import kl_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_WORD   = 3'b010,
        MODE_NUMBER = 3'b100
    } t_mode;

    t_mode                   r_mode, n_mode;
    logic [OFFSET_BITS-1:0]  r_offset, n_offset;
    logic [START_W-1:0]      r_start, n_start;
    logic [LEN_W-1:0]        r_len, n_len;
    logic [NUM_KW-1:0]       r_cand, n_cand;

    logic                    accept;
    logic                    is_letter, is_digit, is_op, close;
    logic [START_W-1:0]      off16;
    t_tok                    tok_close, tok_op, tok_flush;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign off16   = START_W'(r_offset);

    // byte classes
    always_comb begin
        is_letter = i_byte inside {[8'h61:8'h7a], [8'h41:8'h5a], 8'h5f};
        is_digit  = i_byte inside {[8'h30:8'h39]};
        is_op     = i_byte inside {8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h3d, 8'h3e, 8'h3c};
    end

    // scanner next state and tokens closed by this byte
    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_len    = r_len;
        n_cand   = r_cand;
        n_offset = i_eos ? '0 : r_offset + 1'b1;

        close = ((r_mode == MODE_WORD) && !(is_letter || is_digit)) ||
                ((r_mode == MODE_NUMBER) && !is_digit);

        tok_close       = '0;
        tok_close.valid = close;
        tok_close.kind  = (r_mode == MODE_WORD) ? KIND_IDENT : KIND_NUMBER;
        tok_close.cand  = r_cand;
        tok_close.start = r_start;
        tok_close.len   = r_len;

        tok_op       = '0;
        tok_op.kind  = KIND_OPERATOR;
        tok_op.start = off16;
        tok_op.len   = LEN_W'(1);
        tok_op.op    = i_byte;

        if (close) begin
            n_mode = MODE_IDLE;
            n_len  = '0;
            n_cand = CAND_ALL;
        end

        if (close || (r_mode == MODE_IDLE)) begin
            // start a fresh token or report an operator
            if (is_letter || is_digit) begin
                n_mode  = is_letter ? MODE_WORD : MODE_NUMBER;
                n_start = off16;
                n_len   = LEN_W'(1);
                n_cand  = is_letter ? cand_step(CAND_ALL, '0, i_byte) : CAND_ALL;
            end else if (is_op) begin
                tok_op.valid = 1'b1;
            end
        end else begin
            // extend the open token
            n_len  = (r_len == LEN_MAX) ? r_len : r_len + 1'b1;
            n_cand = (r_mode == MODE_WORD) ? cand_step(r_cand, r_len, i_byte) : r_cand;
        end

        // end of source flushes whatever is still open
        tok_flush       = '0;
        tok_flush.valid = i_eos && (n_mode != MODE_IDLE);
        tok_flush.kind  = (n_mode == MODE_WORD) ? KIND_IDENT : KIND_NUMBER;
        tok_flush.cand  = n_cand;
        tok_flush.start = n_start;
        tok_flush.len   = n_len;
        if (i_eos) begin
            n_mode = MODE_IDLE;
            n_len  = '0;
            n_cand = CAND_ALL;
        end
    end

    // pack up to two tokens in arrival order
    always_comb begin
        if (close) begin
            o_bundle.first  = tok_close;
            o_bundle.second = tok_op.valid ? tok_op : tok_flush;
        end else begin
            o_bundle.first  = tok_op.valid ? tok_op : tok_flush;
            o_bundle.second = '0;
        end
        o_push = accept && o_bundle.first.valid;
    end

    // scanner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_offset <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_cand   <= CAND_ALL;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_offset <= n_offset;
            r_start  <= n_start;
            r_len    <= n_len;
            r_cand   <= n_cand;
        end
    end

    `KL_ASSERT(a_idle_clean, (r_mode != MODE_IDLE) || ((r_len == '0) && (r_cand == CAND_ALL)), "idle scanner holds stale token state")
    `KL_ASSERT(a_open_nonempty, (r_mode == MODE_IDLE) || (r_len != '0), "open token with zero length")
    `KL_ASSERT_NEXT(a_eos_restart, accept && i_eos, (r_offset == '0) && (r_mode == MODE_IDLE), "end of source did not restart the scanner")

endmodule

@@ rtl/kl_queue.sv @@
`include "keyword_lexer_assert.svh"

module kl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kl_pkg::t_bundle  i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output kl_pkg::t_bundle  o_data
);
    import kl_pkg::*;

    t_bundle              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `KL_ASSERT(a_count_range, r_count <= Q_CNT_W'(Q_DEPTH), "queue count above depth")
    `KL_ASSERT(a_no_overflow, !(i_push && o_full), "push into a full queue")
    `KL_ASSERT_NEXT(a_push_grows, i_push && !do_pop, r_count == $past(r_count) + 1'b1, "push lost")

endmodule

@@ rtl/kl_back.sv @@
`include "keyword_lexer_assert.svh"

module kl_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  kl_pkg::t_bundle  i_q_data,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output kl_pkg::t_rec     o_rec,
    output logic             o_last
);
    import kl_pkg::*;

    logic    r_valid;
    logic    r_sel;
    logic    r_has_second;
    t_rec    r_rec [2];
    logic    take, done, load;

    // resolve a word against the surviving keyword candidates
    function automatic t_rec resolve(input t_tok t);
        t_rec r;
        r.kind   = t.kind;
        r.kw_idx = '0;
        r.start  = t.start;
        r.len    = t.len;
        r.op     = t.op;
        if (t.kind == KIND_IDENT) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (t.cand[k] && (t.len == KW_LEN[k])) begin
                    r.kind   = KIND_KEYWORD;
                    r.kw_idx = KW_IDX_W'(k);
                end
            end
        end
        return r;
    endfunction

    assign o_valid = r_valid;
    assign o_rec   = r_rec[r_sel];
    assign o_last  = r_sel || !r_has_second;
    assign take    = r_valid && i_ready;
    assign done    = take && o_last;
    assign load    = !r_valid || done;
    assign o_q_pop = load && i_q_valid;

    // result records, loaded one bundle at a time
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec[0] <= resolve(i_q_data.first);
            r_rec[1] <= resolve(i_q_data.second);
        end
    end

    // serializer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_sel        <= 1'b0;
            r_has_second <= 1'b0;
        end else if (load) begin
            r_valid      <= i_q_valid;
            r_sel        <= 1'b0;
            r_has_second <= i_q_valid && i_q_data.second.valid;
        end else if (take) begin
            r_sel <= 1'b1;
        end
    end

    `KL_ASSERT(a_sel_valid, !r_sel || (r_valid && r_has_second), "second slot selected without a second result")
    `KL_ASSERT(a_kw_range, !(r_valid && (o_rec.kind == KIND_KEYWORD)) || (o_rec.kw_idx < KW_IDX_W'(NUM_KW)), "keyword index out of range")
    `KL_ASSERT(a_op_zero, !(r_valid && (o_rec.kind != KIND_OPERATOR)) || (o_rec.op == 8'h00), "operator byte set on a non-operator token")

endmodule
